FILE: src/wrt_pkg.sv
// ----------------------------------------------------------------------------
// wrt_pkg
// Shared types and constants for the weighted roulette table.
// ----------------------------------------------------------------------------
`default_nettype none

package wrt_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int HANDLE_BITS    = 32;
    localparam int WEIGHT_BITS    = 16;
    localparam int FRAC_BITS      = 17;
    localparam int FRAC_SHIFT     = 16;
    localparam int OUT_COUNT_BITS = 7;
    localparam int OUT_TOTAL_BITS = 22;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_GET = 2'd1;
    localparam logic [1:0] OP_POP = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]             op;
        logic [HANDLE_BITS-1:0] handle_in;
        logic [WEIGHT_BITS-1:0] weight_in;
        logic [FRAC_BITS-1:0]   rand_fraction;
    } wrt_req_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0]    handle_out;
        logic [1:0]                status;
        logic [OUT_COUNT_BITS-1:0] entry_count;
        logic [OUT_TOTAL_BITS-1:0] weight_total;
    } wrt_rsp_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [WEIGHT_BITS-1:0] weight;
    } wrt_entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_SHIFT,
        S_DONE
    } wrt_state_t;

endpackage

`default_nettype wire

FILE: src/wrt_ram.sv
// ----------------------------------------------------------------------------
// wrt_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/wrt_pick.sv
// ----------------------------------------------------------------------------
// wrt_pick
// Scales the random fraction by the current total weight and saturates it.
// ----------------------------------------------------------------------------
`default_nettype none

module wrt_pick #(
    parameter int DEPTH = wrt_pkg::DEPTH_DEF,
    localparam int TOT_W = wrt_pkg::WEIGHT_BITS + $clog2(DEPTH + 1)
) (
    input  logic                             clk,
    input  logic                             load,
    input  logic [wrt_pkg::FRAC_BITS-1:0]    fraction,
    input  logic [TOT_W-1:0]                 total,
    output logic [TOT_W-1:0]                 pick
);

    import wrt_pkg::*;

    localparam int PROD_W = FRAC_BITS + TOT_W;
    localparam int SC_W   = PROD_W - FRAC_SHIFT;

    logic [PROD_W-1:0] prod;
    logic [SC_W-1:0]   scaled;
    logic [TOT_W-1:0]  pick_next;
    logic [TOT_W-1:0]  pick_reg;

    assign prod   = PROD_W'(fraction) * PROD_W'(total);
    assign scaled = prod[PROD_W-1:FRAC_SHIFT];

    // A fraction above one would point past the total; clamp it there.
    assign pick_next = (scaled > SC_W'(total)) ? total : scaled[TOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pick_reg <= pick_next;
        end
    end

    assign pick = pick_reg;

endmodule

`default_nettype wire

FILE: src/wrt_seq.sv
// ----------------------------------------------------------------------------
// wrt_seq
// Sequencer: add, weighted walk over the entry RAM, removal by shifting,
// count and total registers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wrt_seq #(
    parameter int DEPTH  = wrt_pkg::DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int TOT_W = wrt_pkg::WEIGHT_BITS + CNT_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  wrt_pkg::wrt_req_t   req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output wrt_pkg::wrt_rsp_t   rsp,
    output logic                pick_load,
    output logic [TOT_W-1:0]    total,
    input  logic [TOT_W-1:0]    pick,
    output logic                mem_we,
    output logic [IDX_W-1:0]    mem_waddr,
    output wrt_pkg::wrt_entry_t mem_wdata,
    output logic                mem_re,
    output logic [IDX_W-1:0]    mem_raddr,
    input  wrt_pkg::wrt_entry_t mem_rdata
);

    import wrt_pkg::*;

    wrt_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic [1:0]             op_reg, op_next;
    logic [IDX_W-1:0]       addr_reg, addr_next;
    logic [IDX_W-1:0]       chk_reg, chk_next;
    logic                   more_reg, more_next;
    logic                   pend_reg, pend_next;
    logic [TOT_W-1:0]       accum_reg, accum_next;
    logic [HANDLE_BITS-1:0] hdl_reg, hdl_next;
    logic [1:0]             stat_reg, stat_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    wrt_rsp_t               rsp_reg, rsp_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic             is_select;
    logic             rsp_free;
    logic [TOT_W-1:0] acc_sum;
    logic             hit;
    logic             shift_needed;
    logic             shift_end;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign is_select = (req.op == OP_GET) || (req.op == OP_POP);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // The walk stops at the first entry where the running sum reaches the pick
    // value; the oldest entry is taken when no newer one qualifies.
    assign acc_sum = accum_reg + TOT_W'(mem_rdata.weight);
    assign hit     = pend_reg && ((acc_sum >= pick) || (chk_reg == '0));

    // Removing anything but the newest entry moves the newer ones down by one.
    assign shift_needed = (CNT_W'(chk_reg) != (count_reg - CNT_W'(1)));
    assign shift_end    = (CNT_W'(addr_reg) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_select && !empty)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_WALK:
            begin
                if (hit)
                begin
                    if ((op_reg == OP_POP) && shift_needed)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT:
            begin
                if (pend_reg && !more_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next     = count_reg;
        total_next     = total_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        chk_next       = chk_reg;
        more_next      = more_reg;
        pend_next      = pend_reg;
        accum_next     = accum_reg;
        hdl_next       = hdl_reg;
        stat_next      = stat_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        pick_load      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = chk_reg - IDX_W'(1);
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = addr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.op;
                    hdl_next   = '0;
                    stat_next  = STAT_OK;
                    accum_next = '0;
                    pend_next  = 1'b0;
                    more_next  = 1'b1;
                    addr_next  = IDX_W'(count_reg - CNT_W'(1));
                    pick_load  = 1'b1;
                    if (req.op == OP_ADD)
                    begin
                        if (full)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_we           = 1'b1;
                            mem_waddr        = IDX_W'(count_reg);
                            mem_wdata.handle = req.handle_in;
                            mem_wdata.weight = req.weight_in;
                            count_next       = count_reg + CNT_W'(1);
                            total_next       = total_reg + TOT_W'(req.weight_in);
                        end
                    end
                    else if (is_select && empty)
                    begin
                        stat_next = STAT_EMPTY;
                    end
                end
            end
            S_WALK:
            begin
                // Reads stream one per cycle; data arrives in the cycle after its read.
                mem_re    = more_reg;
                pend_next = more_reg;
                if (more_reg)
                begin
                    chk_next  = addr_reg;
                    addr_next = addr_reg - IDX_W'(1);
                    more_next = (addr_reg != '0);
                end
                if (pend_reg)
                begin
                    accum_next = acc_sum;
                end
                if (hit)
                begin
                    hdl_next  = mem_rdata.handle;
                    pend_next = 1'b0;
                    more_next = 1'b1;
                    addr_next = chk_reg + IDX_W'(1);
                    if (op_reg == OP_POP)
                    begin
                        total_next = total_reg - TOT_W'(mem_rdata.weight);
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            S_SHIFT:
            begin
                // Read entry j+1 and write it to entry j in the next cycle.
                mem_re    = more_reg;
                pend_next = more_reg;
                if (more_reg)
                begin
                    chk_next  = addr_reg;
                    addr_next = addr_reg + IDX_W'(1);
                    more_next = !shift_end;
                end
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.handle_out   = hdl_reg;
                    rsp_next.status       = stat_reg;
                    rsp_next.entry_count  = OUT_COUNT_BITS'(count_reg);
                    rsp_next.weight_total = OUT_TOTAL_BITS'(total_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            more_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            more_reg      <= more_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        addr_reg  <= addr_next;
        chk_reg   <= chk_next;
        accum_reg <= accum_next;
        hdl_reg   <= hdl_next;
        stat_reg  <= stat_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign total     = total_reg;

endmodule

`default_nettype wire

FILE: src/weighted_roulette_table.sv
// Add, errors and op code three go from the idle state to the done state and then to the
// result register; a selection first walks n entries newest first (n from 1 to count), and
// removing an entry k below the newest then moves the newer ones down by one.
// The table works on one item at a time: a new request is accepted only in the idle state.
// Reset clears count, total and handshake state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// weighted_roulette_table
// Table of weighted handles with fitness-proportionate selection and removal.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_roulette_table #(
    parameter int DEPTH = wrt_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  wrt_pkg::wrt_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output wrt_pkg::wrt_rsp_t rsp
);

    import wrt_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int TOT_W = WEIGHT_BITS + $clog2(DEPTH + 1);

    logic             pick_load;
    logic [TOT_W-1:0] total;
    logic [TOT_W-1:0] pick;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    wrt_entry_t       mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    wrt_entry_t       mem_rdata;

    wrt_ram #(
        .WIDTH ($bits(wrt_entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    wrt_pick #(
        .DEPTH (DEPTH)
    ) u_pick (
        .clk      (clk),
        .load     (pick_load),
        .fraction (req.rand_fraction),
        .total    (total),
        .pick     (pick)
    );

    wrt_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .pick_load (pick_load),
        .total     (total),
        .pick      (pick),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

FILE: src/wrt_checker.sv
// ----------------------------------------------------------------------------
// wrt_checker
// Port-level checks for the weighted roulette table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wrt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input wrt_pkg::wrt_rsp_t rsp
);

    import wrt_pkg::*;

    // The block works on one item at a time, so it is busy right after a transfer.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while the previous one is still in work");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed or dropped");

    a_err_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != STAT_OK) |-> (rsp.handle_out == '0))
        else $error("error result carries a handle");

    a_empty_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_EMPTY)
        |-> (rsp.entry_count == '0) && (rsp.weight_total == '0))
        else $error("empty status with entries or weight left");

endmodule

bind weighted_roulette_table wrt_checker u_wrt_checker (.*);

`default_nettype wire
